// File: design/mksd_pkg.sv
// ----------------------------------------------------------------------------
// mksd_pkg: shared definitions for the key matrix scanner
// Field widths, defaults, constants and the structs that pass between the
// stages of the scanner.
// ----------------------------------------------------------------------------
package mksd_pkg;

  localparam int ROW_COUNT_DEF = 4;
  localparam int COLUMNS_DEF   = 4;
  localparam int MAX_EVENTS    = 4;

  localparam int ROW_W       = 2;
  localparam int COL_LEVEL_W = 4;
  localparam int TIME_W      = 32;
  localparam int DEBOUNCE_W  = 8;
  localparam int KEY_CODE_W  = 5;
  localparam int EVT_CNT_W   = (MAX_EVENTS > 1) ? $clog2(MAX_EVENTS) : 1;

  localparam logic [DEBOUNCE_W-1:0] DEBOUNCE_RESET = 8'd15;

  // One row sample, last field in the lowest bits.
  typedef struct packed {
    logic [TIME_W-1:0]      now_ms;
    logic [COL_LEVEL_W-1:0] column_levels;
    logic [ROW_W-1:0]       row_index;
  } sample_t;

  localparam int SAMPLE_W    = $bits(sample_t);
  localparam int IN_TDATA_W  = ((SAMPLE_W + 7) / 8) * 8;
  localparam int OUT_TDATA_W = ((KEY_CODE_W + 7) / 8) * 8;

  // One key event as presented on the output side.
  typedef struct packed {
    logic [KEY_CODE_W-1:0] key_code;
    logic                  last_event;
  } beat_t;

endpackage

// File: design/mksd_key_state.sv
// ----------------------------------------------------------------------------
// mksd_key_state: per-key debounce state and row evaluation
// Holds the raw level, stable level and change time of every key, works out
// the new state of the sampled row and writes it back when the sample retires.
// ----------------------------------------------------------------------------
module mksd_key_state #(
  parameter int ROW_COUNT = 4,
  parameter int COLUMNS   = 4
) (
  input  logic                            clk,
  input  logic                            rst,
  input  mksd_pkg::sample_t               sample,
  input  logic [mksd_pkg::DEBOUNCE_W-1:0] settle_ms,
  input  logic                            commit,
  output logic [COLUMNS-1:0]              press_mask
);
  import mksd_pkg::*;

  localparam int RSEL_W = (ROW_COUNT > 1) ? $clog2(ROW_COUNT) : 1;

  logic [COLUMNS-1:0] raw_level    [ROW_COUNT];
  logic [COLUMNS-1:0] stable_level [ROW_COUNT];
  logic [TIME_W-1:0]  change_time  [ROW_COUNT][COLUMNS];

  logic               row_ok;
  logic [RSEL_W-1:0]  row_sel;
  logic [COLUMNS-1:0] pressed;
  logic [COLUMNS-1:0] settled;
  logic [COLUMNS-1:0] stable_next;
  logic [TIME_W-1:0]  time_next [COLUMNS];

  assign row_ok  = int'(sample.row_index) < ROW_COUNT;
  assign row_sel = RSEL_W'(sample.row_index);

  // Columns wider than the level field read as zero, that is pressed.
  for (genvar c = 0; c < COLUMNS; c++) begin : g_col
    if (c < COL_LEVEL_W) begin : g_in
      assign pressed[c] = ~sample.column_levels[c];
    end else begin : g_beyond
      assign pressed[c] = 1'b1;
    end
  end

  always_comb begin
    for (int c = 0; c < COLUMNS; c++) begin
      time_next[c] = (pressed[c] != raw_level[row_sel][c]) ? sample.now_ms
                                                            : change_time[row_sel][c];
      settled[c]     = (sample.now_ms - time_next[c]) >= TIME_W'(settle_ms);
      stable_next[c] = settled[c] ? pressed[c] : stable_level[row_sel][c];
      press_mask[c]  = row_ok & settled[c] & pressed[c] & ~stable_level[row_sel][c];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      for (int r = 0; r < ROW_COUNT; r++) begin
        raw_level[r]    <= '0;
        stable_level[r] <= '0;
        for (int c = 0; c < COLUMNS; c++) begin
          change_time[r][c] <= '0;
        end
      end
    end else if (commit && row_ok) begin
      raw_level[row_sel]    <= pressed;
      stable_level[row_sel] <= stable_next;
      for (int c = 0; c < COLUMNS; c++) begin
        change_time[row_sel][c] <= time_next[c];
      end
    end
  end

  // The raw level of a retired row follows its sample.
  a_raw_follows: assert property (@(posedge clk) disable iff (rst)
    commit && row_ok |=> raw_level[$past(row_sel)] == $past(pressed))
    else $error("raw level of committed row does not match sample");

  // Every reported press leaves its key stable and pressed.
  a_press_stable: assert property (@(posedge clk) disable iff (rst)
    commit && row_ok |=>
      (stable_level[$past(row_sel)] & $past(press_mask)) == $past(press_mask))
    else $error("reported press not recorded as stable");

  // A row outside the matrix raises no press.
  a_bad_row_quiet: assert property (@(posedge clk) disable iff (rst)
    !row_ok |-> press_mask == '0)
    else $error("press reported for a row outside the matrix");

endmodule

// File: design/mksd_event_out.sv
// ----------------------------------------------------------------------------
// mksd_event_out: key event serialiser
// Holds the press mask of one row and hands out one key code per word, lowest
// column first, at most MAX_EVENTS per row, marking the final one.
// ----------------------------------------------------------------------------
module mksd_event_out #(
  parameter int COLUMNS = 4
) (
  input  logic                       clk,
  input  logic                       rst,
  input  logic                       load,
  input  logic [mksd_pkg::ROW_W-1:0] load_row,
  input  logic [COLUMNS-1:0]         load_mask,
  output logic                       room,
  output logic                       out_valid,
  output mksd_pkg::beat_t            beat,
  input  logic                       out_ready
);
  import mksd_pkg::*;

  localparam int COL_W = (COLUMNS > 1) ? $clog2(COLUMNS) : 1;

  logic                 ev_valid;
  logic [ROW_W-1:0]     ev_row;
  logic [COLUMNS-1:0]   ev_mask;
  logic [EVT_CNT_W-1:0] ev_count;

  logic [COL_W-1:0]   col;
  logic [COLUMNS-1:0] rest;
  logic               last;
  logic               fire;
  logic               done;

  always_comb begin
    col = '0;
    for (int c = COLUMNS - 1; c >= 0; c--) begin
      if (ev_mask[c]) begin
        col = COL_W'(c);
      end
    end
  end

  assign rest = ev_mask & (ev_mask - 1'b1);
  assign last = (rest == '0) || (ev_count == EVT_CNT_W'(MAX_EVENTS - 1));
  assign fire = ev_valid && out_ready;
  assign done = fire && last;
  assign room = !ev_valid || done;

  assign out_valid       = ev_valid;
  assign beat.key_code   = KEY_CODE_W'(int'(ev_row) * COLUMNS + int'(col) + 1);
  assign beat.last_event = last;

  always_ff @(posedge clk) begin
    if (rst) begin
      ev_valid <= 1'b0;
      ev_count <= '0;
    end else if (load) begin
      ev_valid <= 1'b1;
      ev_count <= '0;
    end else if (done) begin
      ev_valid <= 1'b0;
    end else if (fire) begin
      ev_count <= EVT_CNT_W'(ev_count + 1'b1);
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      ev_row  <= load_row;
      ev_mask <= load_mask;
    end else if (fire) begin
      ev_mask <= rest;
    end
  end

  // A pending row always has at least one key left to report.
  a_mask_nonempty: assert property (@(posedge clk) disable iff (rst)
    ev_valid |-> ev_mask != '0)
    else $error("event register valid with empty mask");

  // Only a free register is loaded, and only with a press.
  a_load_ok: assert property (@(posedge clk) disable iff (rst)
    load |-> room && load_mask != '0)
    else $error("event register loaded while busy or with no press");

  // A word that is not the last keeps the row pending.
  a_not_last_holds: assert property (@(posedge clk) disable iff (rst)
    fire && !last |=> ev_valid)
    else $error("row dropped before its last event");

endmodule

// File: design/matrix_key_scan_debounce.sv
// ----------------------------------------------------------------------------
// matrix_key_scan_debounce: key matrix row scanner with per-key debounce
// Takes sampled matrix rows, debounces every key against a millisecond
// timestamp and reports the code of each newly pressed key.
// ----------------------------------------------------------------------------
//
//  Channel   Dir  Handshake               Word contents (lowest bit first)
//  -------   ---  ---------               --------------------------------
//  cfg       in   cfg_valid / cfg_ready   settle_ms[7:0]
//  s_*       in   s_tvalid  / s_tready    row_index[1:0], column_levels[5:2],
//                                         now_ms[37:6], zero pad to 40 bits
//  m_*       out  m_tvalid  / m_tready    key_code[4:0], zero pad; tlast marks
//                                         the final event of a row
//
// A row sample is registered on entry and evaluated in the following cycle;
// it retires there at once when it raises no press, so rows without presses
// flow at one word per cycle. A row with n new presses (n capped at four)
// then occupies the event register for n output words, one per cycle while
// m_tready is high.
// The input register takes one more sample while the event register drains;
// rows without presses retire past a busy event register, but the next row
// with presses has to wait in the input register until the last word leaves.
// Reset (rst, synchronous) releases every key, zeroes all change times and
// restores the debounce setting to 15 ms; there is no clearing pass.
// A stall on m_tready holds the event register and, once the next row with
// presses is waiting behind it, the input register as well.
// ----------------------------------------------------------------------------
module matrix_key_scan_debounce #(
  parameter int ROW_COUNT = mksd_pkg::ROW_COUNT_DEF,
  parameter int COLUMNS   = mksd_pkg::COLUMNS_DEF
) (
  input  logic                             clk,
  input  logic                             rst,
  // Configuration write: settle_ms
  input  logic                             cfg_valid,
  output logic                             cfg_ready,
  input  logic [mksd_pkg::DEBOUNCE_W-1:0]  cfg_data,
  // Row samples: row_index, column_levels, now_ms
  input  logic                             s_tvalid,
  output logic                             s_tready,
  input  logic [mksd_pkg::IN_TDATA_W-1:0]  s_tdata,
  // Key events: key_code
  output logic                             m_tvalid,
  input  logic                             m_tready,
  output logic [mksd_pkg::OUT_TDATA_W-1:0] m_tdata,
  output logic                             m_tlast
);
  import mksd_pkg::*;

  // Debounce setting; the user must write it only while the scanner is idle, the block itself does not enforce this.
  logic [DEBOUNCE_W-1:0] settle_ms;

  // Input register holding the row under evaluation.
  logic    s1_valid;
  sample_t s1_sample;

  logic [COLUMNS-1:0] press_mask;
  logic               has_press;
  logic               room;
  logic               retire;
  logic               load;
  beat_t              beat;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      settle_ms <= DEBOUNCE_RESET;
    end else if (cfg_valid && cfg_ready) begin
      settle_ms <= cfg_data;
    end
  end

  // A row retires when it raised no press, or when the event register can
  // take its press mask in this cycle. Key state is written back on retire,
  // so a following sample of the same row sees the updated levels.
  assign has_press = |press_mask;
  assign retire    = s1_valid && (!has_press || room);
  assign load      = s1_valid && has_press && room;
  assign s_tready  = !s1_valid || retire;

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else if (s_tready) begin
      s1_valid <= s_tvalid;
    end
  end

  always_ff @(posedge clk) begin
    if (s_tvalid && s_tready) begin
      s1_sample <= sample_t'(s_tdata[SAMPLE_W-1:0]);
    end
  end

  mksd_key_state #(
    .ROW_COUNT (ROW_COUNT),
    .COLUMNS   (COLUMNS)
  ) u_key_state (
    .clk        (clk),
    .rst        (rst),
    .sample     (s1_sample),
    .settle_ms  (settle_ms),
    .commit     (retire),
    .press_mask (press_mask)
  );

  mksd_event_out #(
    .COLUMNS (COLUMNS)
  ) u_event_out (
    .clk       (clk),
    .rst       (rst),
    .load      (load),
    .load_row  (s1_sample.row_index),
    .load_mask (press_mask),
    .room      (room),
    .out_valid (m_tvalid),
    .beat      (beat),
    .out_ready (m_tready)
  );

  assign m_tdata = OUT_TDATA_W'(beat.key_code);
  assign m_tlast = beat.last_event;

  // A row that cannot retire stays in the input register unchanged.
  a_row_held: assert property (@(posedge clk) disable iff (rst)
    s1_valid && !retire |=> s1_valid && $stable(s1_sample))
    else $error("pending row lost or altered while blocked");

  // A row with presses only retires into the event register.
  a_press_loads: assert property (@(posedge clk) disable iff (rst)
    retire && has_press |-> load)
    else $error("row with presses retired without loading events");

  // A loaded row shows its first event in the next cycle.
  a_load_shows: assert property (@(posedge clk) disable iff (rst)
    load |=> m_tvalid)
    else $error("loaded events not presented");

endmodule

// File: tb/sv/matrix_key_scan_debounce_test.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// matrix_key_scan_debounce_test: self-checking bench for the key scanner
// Scanned matrix rows are driven in with a timestamp that mostly advances
// from one word to the next. Physical key presses persist over many scans
// and bounce now and then. An independent debounce model predicts every
// key code. Each output word is checked against the oldest prediction.
// The debounce setting is changed between phases while the scanner is idle.
// ----------------------------------------------------------------------------
module matrix_key_scan_debounce_test;
  import mksd_pkg::*;

  localparam int KEYS = ROW_COUNT_DEF * COLUMNS_DEF;

  // Debounce model of the whole matrix, with a queue of predicted key events.
  class key_event_board;
    bit                    raw_pressed[KEYS];
    bit                    stable_pressed[KEYS];
    logic [TIME_W-1:0]     last_change[KEYS];
    logic [DEBOUNCE_W-1:0] hold_ms;
    beat_t                 predicted[$];
    int                    errors;

    function void clear_keys();
      foreach (raw_pressed[k]) begin
        raw_pressed[k]    = 1'b0;
        stable_pressed[k] = 1'b0;
        last_change[k]    = '0;
      end
      hold_ms = DEBOUNCE_RESET;
      predicted.delete();
      errors = 0;
    endfunction

    function void set_debounce(logic [DEBOUNCE_W-1:0] value);
      hold_ms = value;
    endfunction

    // An accepted row sample: debounce its keys and queue any new presses.
    function void note_sample(sample_t s);
      beat_t             found[$];
      beat_t             b;
      int                k;
      bit                pressed;
      logic [TIME_W-1:0] elapsed;
      if (s.row_index >= ROW_COUNT_DEF)
        return;
      for (int c = 0; c < COLUMNS_DEF; c++) begin
        k       = s.row_index * COLUMNS_DEF + c;
        pressed = !s.column_levels[c];
        if (pressed != raw_pressed[k]) begin
          last_change[k] = s.now_ms;
          raw_pressed[k] = pressed;
        end
        elapsed = s.now_ms - last_change[k];
        if (elapsed >= TIME_W'(hold_ms)) begin
          if (pressed && !stable_pressed[k] && found.size() < MAX_EVENTS) begin
            b.key_code   = KEY_CODE_W'(k + 1);
            b.last_event = 1'b0;
            found.push_back(b);
          end
          stable_pressed[k] = pressed;
        end
      end
      if (found.size() > 0)
        found[found.size() - 1].last_event = 1'b1;
      foreach (found[i])
        predicted.push_back(found[i]);
    endfunction

    function void check_event(logic [OUT_TDATA_W-1:0] data, logic last);
      beat_t want;
      if (predicted.size() == 0) begin
        $error("key_code: no event expected, actual %0d", data[KEY_CODE_W-1:0]);
        errors++;
        return;
      end
      want = predicted.pop_front();
      if (data[KEY_CODE_W-1:0] !== want.key_code) begin
        $error("key_code: expected %0d, actual %0d", want.key_code,
               data[KEY_CODE_W-1:0]);
        errors++;
      end
      if (data[OUT_TDATA_W-1:KEY_CODE_W] !== '0) begin
        $error("tdata padding: expected 0, actual %0h",
               data[OUT_TDATA_W-1:KEY_CODE_W]);
        errors++;
      end
      if (last !== want.last_event) begin
        $error("last_event: expected %0d, actual %0d", want.last_event, last);
        errors++;
      end
    endfunction

    function int outstanding();
      return predicted.size();
    endfunction
  endclass

  logic                   clk;
  logic                   rst;
  logic                   cfg_valid;
  logic                   cfg_ready;
  logic [DEBOUNCE_W-1:0]  cfg_data;
  logic                   s_tvalid;
  logic                   s_tready;
  logic [IN_TDATA_W-1:0]  s_tdata;   // row_index, column_levels, now_ms, pad
  logic                   m_tvalid;
  logic                   m_tready;
  logic [OUT_TDATA_W-1:0] m_tdata;   // key_code, pad
  logic                   m_tlast;

  key_event_board board;

  int                    send_idle_pct;
  int                    recv_stall_pct;
  int                    hold_cycles;
  logic [DEBOUNCE_W-1:0] debounce_now;
  logic [TIME_W-1:0]     clock_ms;
  int                    scan_row;
  bit                    finger_down[KEYS];

  matrix_key_scan_debounce u_dut (
    .clk       (clk),
    .rst       (rst),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_data  (cfg_data),
    .s_tvalid  (s_tvalid),
    .s_tready  (s_tready),
    .s_tdata   (s_tdata),
    .m_tvalid  (m_tvalid),
    .m_tready  (m_tready),
    .m_tdata   (m_tdata),
    .m_tlast   (m_tlast)
  );

  initial clk = 1'b0;
  always #4 clk = ~clk;

  initial begin
    #4_000_000;
    $display("CHECK FAILED");
    $finish;
  end

  // Receiver: random back-pressure, or a long hold-off when one is requested.
  always @(negedge clk) begin
    if (hold_cycles > 0) begin
      m_tready <= 1'b0;
      hold_cycles = hold_cycles - 1;
    end else begin
      m_tready <= ($urandom_range(0, 99) >= recv_stall_pct);
    end
  end

  always @(posedge clk) begin
    if (!rst && m_tvalid && m_tready)
      board.check_event(m_tdata, m_tlast);
  end

  // Entered and left at a falling edge; tvalid stays up for a following word.
  task automatic send_sample(logic [ROW_W-1:0] row, logic [COL_LEVEL_W-1:0] cols,
                             logic [TIME_W-1:0] stamp);
    sample_t s;
    s.row_index     = row;
    s.column_levels = cols;
    s.now_ms        = stamp;
    while ($urandom_range(0, 99) < send_idle_pct) begin
      s_tvalid <= 1'b0;
      @(negedge clk);
    end
    s_tvalid <= 1'b1;
    s_tdata  <= IN_TDATA_W'(s);
    @(posedge clk);
    while (!s_tready) @(posedge clk);
    board.note_sample(s);
    @(negedge clk);
  endtask

  // Stop offering words and wait for every predicted event, then let rows
  // that raised no press leave the pipeline.
  task automatic drain_events();
    s_tvalid <= 1'b0;
    @(negedge clk);
    while (board.outstanding() != 0) @(negedge clk);
    repeat (8) @(negedge clk);
  endtask

  task automatic write_debounce(logic [DEBOUNCE_W-1:0] value);
    drain_events();
    cfg_valid <= 1'b1;
    cfg_data  <= value;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    board.set_debounce(value);
    debounce_now = value;
    @(negedge clk);
    cfg_valid <= 1'b0;
  endtask

  // Hand-picked rows at the reset debounce of 15 ms: full rows, partial rows,
  // a bounce, a hold one millisecond short, and the timestamp wrapping.
  task automatic directed_rows();
    send_sample(2'd0, 4'h0, 32'd0);
    send_sample(2'd0, 4'h0, 32'd15);
    send_sample(2'd3, 4'h0, 32'd20);
    send_sample(2'd3, 4'h0, 32'd35);
    send_sample(2'd1, 4'b1010, 32'd40);
    send_sample(2'd1, 4'b1010, 32'd55);
    send_sample(2'd2, 4'hF, 32'd60);
    send_sample(2'd0, 4'hF, 32'd70);
    send_sample(2'd0, 4'hF, 32'd85);
    send_sample(2'd0, 4'b1110, 32'd90);
    send_sample(2'd0, 4'hF, 32'd95);
    send_sample(2'd0, 4'b1110, 32'd100);
    send_sample(2'd0, 4'b1110, 32'd114);
    send_sample(2'd0, 4'b1110, 32'd115);
    send_sample(2'd2, 4'h0, 32'hFFFF_FFF8);
    send_sample(2'd2, 4'h0, 32'hFFFF_FFFF);
    send_sample(2'd2, 4'h0, 32'h0000_0007);
    send_sample(2'd1, 4'b0101, 32'h8000_0000);
    send_sample(2'd1, 4'b0101, 32'h8000_0010);
    send_sample(2'd3, 4'hF, 32'h8000_0020);
  endtask

  // Mostly an orderly scan of a matrix whose keys are held and released by
  // a simulated hand, with bounce on the columns; the rest is pure noise.
  task automatic scan_rows(int count);
    logic [ROW_W-1:0]       row;
    logic [COL_LEVEL_W-1:0] cols;
    int                     k;
    for (int i = 0; i < count; i++) begin
      if ($urandom_range(0, 99) < 10) begin
        row      = ROW_W'($urandom_range(0, ROW_COUNT_DEF - 1));
        cols     = COL_LEVEL_W'($urandom);
        clock_ms = clock_ms + $urandom_range(0, 3);
      end else begin
        row      = ROW_W'(scan_row);
        scan_row = (scan_row + 1) % ROW_COUNT_DEF;
        for (int c = 0; c < COLUMNS_DEF; c++) begin
          k = row * COLUMNS_DEF + c;
          if ($urandom_range(0, 19) == 0)
            finger_down[k] = !finger_down[k];
          cols[c] = !finger_down[k];
        end
        if ($urandom_range(0, 9) == 0)
          cols[$urandom_range(0, COLUMNS_DEF - 1)] ^= 1'b1;
        if ($urandom_range(0, 49) == 0)
          clock_ms = $urandom;
        else
          clock_ms = clock_ms + $urandom_range(0, debounce_now / 3 + 2);
      end
      send_sample(row, cols, clock_ms);
      if ($urandom_range(0, 59) == 0)
        drain_events();
    end
  endtask

  // With zero debounce, alternate whole rows pressed and released while the
  // receiver holds off, so the event register and input register both fill.
  task automatic burst_under_hold();
    hold_cycles = 300;
    for (int i = 0; i < 24; i++) begin
      clock_ms = clock_ms + 1;
      send_sample(ROW_W'(i % ROW_COUNT_DEF), ((i / ROW_COUNT_DEF) % 2 == 0) ? 4'h0 : 4'hF,
                  clock_ms);
    end
  endtask

  initial begin
    board          = new;
    board.clear_keys();
    rst            = 1'b1;
    cfg_valid      = 1'b0;
    cfg_data       = '0;
    s_tvalid       = 1'b0;
    s_tdata        = '0;
    m_tready       = 1'b0;
    send_idle_pct  = 0;
    recv_stall_pct = 0;
    hold_cycles    = 0;
    debounce_now   = DEBOUNCE_RESET;
    clock_ms       = 32'hFFFF_FFC0;
    scan_row       = 0;
    foreach (finger_down[k]) finger_down[k] = 1'b0;
    repeat (4) @(negedge clk);
    rst <= 1'b0;
    @(negedge clk);

    directed_rows();

    // Zero debounce; the sender idles lightly and the receiver heavily.
    write_debounce(8'd0);
    send_idle_pct  = 16;
    recv_stall_pct = 55;
    scan_rows(130);

    // Longest debounce, with the idling the other way round.
    write_debounce(8'd255);
    send_idle_pct  = 55;
    recv_stall_pct = 16;
    scan_rows(130);

    // A middling setting at full rate.
    write_debounce(DEBOUNCE_W'($urandom_range(1, 254)));
    send_idle_pct  = 0;
    recv_stall_pct = 0;
    scan_rows(130);

    write_debounce(8'd0);
    burst_under_hold();
    drain_events();
    scan_rows(60);

    drain_events();
    repeat (16) @(negedge clk);
    if (board.errors == 0 && board.outstanding() == 0) begin
      $display("CHECK OK");
    end else begin
      $display("CHECK FAILED");
    end
    $finish;
  end

endmodule

// File: matrix_key_scan_debounce.f
design/mksd_pkg.sv
design/mksd_key_state.sv
design/mksd_event_out.sv
design/matrix_key_scan_debounce.sv
tb/sv/matrix_key_scan_debounce_test.sv
